// File: src/assert_macros.svh
//==============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/psfp_pkg.sv
//==============================================================================
// Particle sensor frame parser package
// Frame geometry, header codes and the structs passed between the units.
//==============================================================================
package psfp_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int DATA_WORDS  = 12;

  localparam logic [7:0] HDR0 = 8'h42;
  localparam logic [7:0] HDR1 = 8'h4D;

  localparam int WORD_START = 4;
  localparam int SUM_POS    = FRAME_BYTES - 2;
  localparam int LAST_POS   = FRAME_BYTES - 1;
  localparam int POS_W      = $clog2(FRAME_BYTES);
  localparam int WORDS_ROOM = (SUM_POS > WORD_START) ? (SUM_POS - WORD_START) / 2 : 0;
  localparam int WORDS_IN_FRAME = (WORDS_ROOM < DATA_WORDS) ? WORDS_ROOM : DATA_WORDS;
  localparam int WIDX_W     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic              en;
    logic              lo;
    logic [WIDX_W-1:0] idx;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic good;
  } frame_done_t;

endpackage

// File: src/psfp_if.sv
//==============================================================================
// Particle sensor frame parser channels
// Valid/ready channels for received bytes and parsed result beats.
//==============================================================================
interface psfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        last;

  modport source (output valid, output status, output word_index, output word_value,
                  output last, input ready);
  modport sink   (input valid, input status, input word_index, input word_value,
                  input last, output ready);
endinterface

// File: src/particle_sensor_frame_parser_unit.sv
// A frame's final byte sets the word emitter busy; the first result beat then goes to the
// output register. Throughput: one byte per cycle while the emitter is idle; it holds off
// input until its last result (of twelve for a good frame, one for a bad one) is loaded.
// Reset: synchronous, active low; clears header hunt, sums and handshake state.
// The word store is not cleared and is always written before it is read.
//==============================================================================
// Particle sensor frame parser
// Parses 32-byte sensor frames into twelve checked 16-bit measurement words.
//==============================================================================
module particle_sensor_frame_parser_unit
  import psfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  psfp_byte_if.sink     in_beat,
  psfp_result_if.source out_beat
);

  store_wr_t   wr;
  frame_done_t done;
  logic        busy;

  psfp_assembler u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .in_beat (in_beat),
    .wr      (wr),
    .done    (done)
  );

  psfp_emitter u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .done     (done),
    .busy     (busy),
    .out_beat (out_beat)
  );

endmodule

// File: src/psfp_assembler.sv
//==============================================================================
// Frame assembler
// Hunts for the header, tracks the byte position and running sum, writes the
// data words to the word store and flags the end of each frame.
//==============================================================================
module psfp_assembler
  import psfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               busy,
  psfp_byte_if.sink          in_beat,
  output store_wr_t          wr,
  output frame_done_t        done
);

  `include "assert_macros.svh"

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       sum_hi_r, sum_hi_nxt;
  logic             acc;
  logic [7:0]       b;
  logic [POS_W-1:0] off;
  logic [POS_W-2:0] widx;

  assign in_beat.ready = !busy;
  assign acc  = in_beat.valid && in_beat.ready;
  assign b    = in_beat.rx_byte;
  assign off  = pos_r - POS_W'(WORD_START);
  assign widx = off[POS_W-1:1];

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    sum_hi_nxt = sum_hi_r;
    wr.en      = 1'b0;
    wr.lo      = off[0];
    wr.idx     = WIDX_W'(widx);
    wr.data    = b;
    done.valid = 1'b0;
    done.good  = ({sum_hi_r, b} == sum_r);
    if (acc) begin
      if (pos_r == '0) begin
        if (b == HDR0) begin
          sum_nxt = 16'(HDR0);
          pos_nxt = POS_W'(1);
        end
      end else if (pos_r == POS_W'(1)) begin
        if (b == HDR1) begin
          sum_nxt = sum_r + 16'(b);
          pos_nxt = POS_W'(2);
        end else if (b == HDR0) begin
          sum_nxt = 16'(HDR0);
          pos_nxt = POS_W'(1);
        end else begin
          sum_nxt = '0;
          pos_nxt = '0;
        end
      end else if (pos_r < POS_W'(SUM_POS)) begin
        sum_nxt = sum_r + 16'(b);
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r >= POS_W'(WORD_START) && widx < (POS_W-1)'(WORDS_IN_FRAME)) begin
          wr.en = 1'b1;
        end
      end else if (pos_r == POS_W'(SUM_POS)) begin
        sum_hi_nxt = b;
        pos_nxt    = pos_r + POS_W'(1);
      end else begin
        done.valid = 1'b1;
        pos_nxt    = '0;
        sum_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      sum_hi_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
  end

  `ASSERT_NXT(a_done_rearms, done.valid, pos_r == '0 && sum_r == '0)
  `ASSERT_IMP(a_wr_in_body, wr.en, pos_r >= POS_W'(WORD_START) && pos_r < POS_W'(SUM_POS))

endmodule

// File: src/psfp_emitter.sv
//==============================================================================
// Result emitter
// Holds the word store and steps through it after a good frame, or sends a
// single error beat after a bad one, through the output register.
//==============================================================================
module psfp_emitter
  import psfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  store_wr_t     wr,
  input  frame_done_t   done,
  output logic          busy,
  psfp_result_if.source out_beat
);

  `include "assert_macros.svh"

  logic [15:0]       mem [DATA_WORDS];
  logic              busy_r, busy_nxt;
  logic              err_r, err_nxt;
  logic [WIDX_W-1:0] idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  logic              st_r;
  logic [3:0]        wi_r;
  logic [15:0]       wv_r;
  logic              last_r;
  logic              load;
  logic              fin;

  assign busy = busy_r;
  assign load = busy_r && (!ov_r || out_beat.ready);
  assign fin  = err_r || (idx_r == WIDX_W'(WORDS_IN_FRAME - 1));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.lo) begin
        mem[wr.idx][7:0] <= wr.data;
      end else begin
        mem[wr.idx] <= {wr.data, 8'h00};
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r && !out_beat.ready;
    if (done.valid) begin
      busy_nxt = !done.good || (WORDS_IN_FRAME != 0);
      err_nxt  = !done.good;
      idx_nxt  = '0;
    end else if (load) begin
      ov_nxt   = 1'b1;
      busy_nxt = !fin;
      idx_nxt  = idx_r + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_r   <= err_r ? STATUS_BAD : STATUS_GOOD;
      wi_r   <= err_r ? 4'd0 : 4'(idx_r);
      wv_r   <= err_r ? 16'd0 : mem[idx_r];
      last_r <= fin;
    end
  end

  assign out_beat.valid      = ov_r;
  assign out_beat.status     = st_r;
  assign out_beat.word_index = wi_r;
  assign out_beat.word_value = wv_r;
  assign out_beat.last       = last_r;

  `ASSERT_IMP(a_done_when_free, done.valid, !busy_r)
  `ASSERT_IMP(a_idx_in_frame, busy_r && !err_r, idx_r < WIDX_W'(WORDS_IN_FRAME))
  `ASSERT_NXT(a_err_single, load && err_r, !busy_r)

endmodule

// File: tb/sv/tb.sv
//==============================================================================
// Particle sensor frame parser testbench
// Feeds byte streams of noise, header resyncs, good frames and frames with a
// corrupted checksum into the parser, predicts every result beat in a
// scoreboard and compares each beat field by field. Both sides idle at
// random, and the result side once holds off long enough to back up input.
//==============================================================================
module tb;
  import psfp_pkg::*;

  localparam int TOTAL_RANDOM_BYTES = 360;
  localparam int PRESSURE_AT_BYTE   = 200;
  localparam int HOLD_CYCLES        = 300;
  localparam int IDLE_LIMIT         = 2000;
  localparam int DRAIN_CYCLES       = 16;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_EXTREMES} fill_kind_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_RARE} sink_mode_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        last;
  } result_beat_t;

  class frame_scoreboard;
    result_beat_t pending_q[$];
    int unsigned  errors;
    int unsigned  beats_checked;
    int unsigned  frames_good;
    int unsigned  frames_bad;
    int unsigned  byte_pos;
    logic [15:0]  frame_sum;
    logic [7:0]   sum_hi;
    logic [15:0]  words [DATA_WORDS];

    function void note_byte(input logic [7:0] b);
      int unsigned  off;
      int unsigned  w;
      int unsigned  i;
      result_beat_t r;
      if (byte_pos == 0) begin
        if (b == HDR0) begin
          frame_sum = 16'(HDR0);
          byte_pos  = 1;
        end
      end else if (byte_pos == 1) begin
        if (b == HDR1) begin
          frame_sum = frame_sum + 16'(b);
          byte_pos  = 2;
        end else if (b == HDR0) begin
          frame_sum = 16'(HDR0);
        end else begin
          frame_sum = '0;
          byte_pos  = 0;
        end
      end else if (byte_pos < SUM_POS) begin
        frame_sum = frame_sum + 16'(b);
        if (byte_pos >= WORD_START) begin
          off = byte_pos - WORD_START;
          w   = off / 2;
          if (w < WORDS_IN_FRAME) begin
            if (off % 2 == 0) begin
              words[w] = {b, 8'h00};
            end else begin
              words[w][7:0] = b;
            end
          end
        end
        byte_pos++;
      end else if (byte_pos == SUM_POS) begin
        sum_hi = b;
        byte_pos++;
      end else begin
        byte_pos = 0;
        if ({sum_hi, b} == frame_sum) begin
          frames_good++;
          for (i = 0; i < WORDS_IN_FRAME; i++) begin
            r.status     = STATUS_GOOD;
            r.word_index = 4'(i);
            r.word_value = words[i];
            r.last       = (i + 1 == WORDS_IN_FRAME);
            pending_q.push_back(r);
          end
        end else begin
          frames_bad++;
          r.status     = STATUS_BAD;
          r.word_index = '0;
          r.word_value = '0;
          r.last       = 1'b1;
          pending_q.push_back(r);
        end
        frame_sum = '0;
      end
    endfunction

    function void check_beat(input result_beat_t got);
      result_beat_t exp;
      beats_checked++;
      if (pending_q.size() == 0) begin
        $error("Result beat arrived with nothing expected: status %0d index %0d value %h",
               got.status, got.word_index, got.word_value);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.word_index !== exp.word_index) begin
        $error("word_index mismatch: expected %0d, got %0d", exp.word_index, got.word_index);
        errors++;
      end
      if (got.word_value !== exp.word_value) begin
        $error("word_value mismatch: expected %h, got %h", exp.word_value, got.word_value);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last mismatch: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending_q.size() != 0) begin
        $error("%0d expected result beats never arrived", pending_q.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psfp_byte_if   in_if ();
  psfp_result_if out_if ();

  particle_sensor_frame_parser_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_if.sink),
    .out_beat(out_if.source)
  );

  frame_scoreboard sb;
  int unsigned     bytes_taken;
  int unsigned     burst_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b);
    bytes_taken++;
  endtask

  function automatic logic [7:0] fill_byte(input fill_kind_t fill);
    case (fill)
      FILL_ONES:     return 8'hFF;
      FILL_ZEROS:    return 8'h00;
      FILL_EXTREMES: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input fill_kind_t fill, input bit corrupt);
    logic [7:0]  frame [FRAME_BYTES];
    logic [15:0] sum;
    int          i;
    int          flip;
    frame[0] = HDR0;
    frame[1] = HDR1;
    for (i = 2; i < SUM_POS; i++) frame[i] = fill_byte(fill);
    sum = '0;
    for (i = 0; i < SUM_POS; i++) sum = sum + 16'(frame[i]);
    frame[SUM_POS]  = sum[15:8];
    frame[LAST_POS] = sum[7:0];
    if (corrupt) begin
      flip = $urandom_range(2, LAST_POS);
      frame[flip][$urandom_range(0, 7)] ^= 1'b1;
    end
    for (i = 0; i < FRAME_BYTES; i++) send_byte(frame[i]);
  endtask

  task automatic send_noise(input int unsigned count, input bit allow_header);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if (allow_header && $urandom_range(0, 3) == 0) b = HDR0;
      send_byte(b);
    end
  endtask

  initial begin : idle_watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_beat('{out_if.status, out_if.word_index, out_if.word_value, out_if.last});
    end
  end

  initial begin : result_sink
    int unsigned cyc;
    int unsigned hold;
    bit          hold_done;
    sink_mode_t  mode;
    out_if.ready <= 1'b0;
    cyc       = 0;
    hold_done = 1'b0;
    mode      = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_taken >= PRESSURE_AT_BYTE) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end
      if (cyc % 48 == 0) mode = sink_mode_t'($urandom_range(0, 3));
      cyc++;
      case (mode)
        SINK_OPEN:     out_if.ready <= 1'b1;
        SINK_COIN:     out_if.ready <= ($urandom_range(0, 1) == 1);
        SINK_PERIODIC: out_if.ready <= (cyc % 5 != 0);
        default:       out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : stimulus
    int unsigned start_count;
    int unsigned pick;
    fill_kind_t  fill;
    sb = new();
    bytes_taken   = 0;
    burst_left    = 0;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Noise outside a frame, a wrong second header byte, a stray second header
    // byte and a doubled first header byte that must stay a header candidate.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR0);
    send_byte(8'h13);
    send_byte(HDR1);
    send_byte(HDR0);
    send_byte(HDR0);
    send_frame(FILL_ONES, 1'b0);
    send_frame(FILL_ZEROS, 1'b1);

    start_count = bytes_taken;
    while (bytes_taken - start_count < TOTAL_RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        case ($urandom_range(0, 9))
          7:       fill = FILL_ONES;
          8:       fill = FILL_ZEROS;
          9:       fill = FILL_EXTREMES;
          default: fill = FILL_RANDOM;
        endcase
        send_frame(fill, $urandom_range(0, 4) == 0);
      end else if (pick < 9) begin
        send_noise($urandom_range(1, 5), 1'b1);
      end else begin
        send_byte(HDR0);
        send_byte(HDR1);
        send_noise($urandom_range(1, 20), 1'b0);
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("Run covered %0d bytes: %0d frames with a good checksum, %0d with a bad one,",
             bytes_taken, sb.frames_good, sb.frames_bad);
    $display("and %0d result beats checked, with one long result-side hold-off.",
             sb.beats_checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/psfp_pkg.sv
src/psfp_if.sv
src/psfp_assembler.sv
src/psfp_emitter.sv
src/particle_sensor_frame_parser_unit.sv
tb/sv/tb.sv
